/* design/tps_pkg.sv */
// Shared constants, types and helper functions of the torus point shader.
`timescale 1ns / 1ps
package tps_pkg;

	// Sine and cosine values in Q1.14.
	typedef logic signed [15:0] trig_t;
	// Rotated coordinates in Q14.
	typedef logic signed [20:0] coord_t;
	// Binary angle, 65536 units per turn.
	typedef logic [15:0] angle_t;

	// Number of register stages from input transfer to output register.
	localparam int NSTG = 24;
	// Quotient bits of each divider, and its operand widths.
	localparam int DIV_QW = 12;
	localparam int MAG_W = 40;
	localparam int DEN_W = 28;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROT_X  = 2'd0;
	localparam logic [1:0] CFG_ROT_Z  = 2'd1;
	localparam logic [1:0] CFG_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_HEIGHT = 2'd3;

	// Step index to binary angle: 0.02 rad in units of 2^-32 turn.
	localparam logic [33:0] STEP_MUL = 34'd13671306;
	localparam logic [33:0] STEP_RND = 34'd32768;

	// Quarter-wave polynomial coefficients.
	localparam logic [14:0] QUARTER = 15'd16384;
	localparam logic [25:0] SIN_C = 26'd1160;
	localparam logic [13:0] SIN_B = 14'd10512;
	localparam logic [14:0] SIN_A = 15'd25736;

	// Torus and view geometry in Q14; the tube radius is a plain integer factor.
	localparam logic signed [19:0] RING_R1 = 20'sd163840;
	localparam logic signed [19:0] TUBE_R2 = 20'sd3;
	localparam logic signed [21:0] VIEW_DIST = 22'sd819200;

	// Projection scale factors.
	localparam logic signed [28:0] PX_MUL = 29'sd74;
	localparam logic signed [28:0] PX_CTR = 29'sd39;
	localparam logic signed [28:0] PY_CTR = 29'sd26;
	localparam logic [27:0] DX_MUL = 28'd78;
	localparam logic [27:0] DY_MUL = 28'd52;

	// Numerator of the inverse depth, one in Q30.
	localparam logic [MAG_W-1:0] OOZ_NUM = MAG_W'(64'h4000_0000);

	// Q14 product scaled back down, truncated toward zero.
	function automatic logic signed [47:0] qtrunc(input logic signed [47:0] p);
		logic signed [47:0] r;
		if (p < 0) begin
			r = (p + 48'sd16383) >>> 14;
		end else begin
			r = p >>> 14;
		end
		return r;
	endfunction

endpackage

/* design/tps_trig.sv */
// Pipelined sine and cosine of one binary angle, four register stages.
`timescale 1ns / 1ps
module tps_trig (
	input  logic                 clk,
	input  logic [3:0]           stage_en,
	input  tps_pkg::angle_t      ang,
	output tps_pkg::trig_t       sin_s5,
	output tps_pkg::trig_t       cos_s5
);
	import tps_pkg::*;

	logic [14:0] x_s2 [2];
	logic        sg_s2 [2];
	logic [14:0] z2_s2 [2];
	logic [14:0] x_s3 [2];
	logic        sg_s3 [2];
	logic [14:0] z2_s3 [2];
	logic [13:0] t1_s3 [2];
	logic [14:0] x_s4 [2];
	logic        sg_s4 [2];
	logic [14:0] t2_s4 [2];
	trig_t       res_s5 [2];

	// Lane 0 gives the sine, lane 1 the cosine as the sine a quarter turn on.
	for (genvar l = 0; l < 2; l++) begin : g_lane
		angle_t      a_c;
		logic [14:0] x_c;

		always_comb begin
			a_c = (l == 0) ? ang : ang + 16'(QUARTER);
			x_c = a_c[14] ? QUARTER - 15'(a_c[13:0]) : 15'(a_c[13:0]);
		end

		// Fold into the first quadrant and square.
		always_ff @(posedge clk) begin
			if (stage_en[0]) begin
				x_s2[l]  <= x_c;
				sg_s2[l] <= a_c[15];
				z2_s2[l] <= 15'((30'(x_c) * 30'(x_c)) >> 14);
			end
		end

		// Innermost polynomial term.
		always_ff @(posedge clk) begin
			if (stage_en[1]) begin
				x_s3[l]  <= x_s2[l];
				sg_s3[l] <= sg_s2[l];
				z2_s3[l] <= z2_s2[l];
				t1_s3[l] <= SIN_B - 14'((SIN_C * 26'(z2_s2[l])) >> 14);
			end
		end

		// Middle polynomial term.
		always_ff @(posedge clk) begin
			if (stage_en[2]) begin
				x_s4[l]  <= x_s3[l];
				sg_s4[l] <= sg_s3[l];
				t2_s4[l] <= SIN_A - 15'((29'(t1_s3[l]) * 29'(z2_s3[l])) >> 14);
			end
		end

		// Final product and sign from the quadrant.
		logic [14:0] t_c;
		assign t_c = 15'((30'(x_s4[l]) * 30'(t2_s4[l])) >> 14);

		always_ff @(posedge clk) begin
			if (stage_en[3]) begin
				res_s5[l] <= sg_s4[l] ? -$signed({1'b0, t_c}) : $signed({1'b0, t_c});
			end
		end
	end

	assign sin_s5 = res_s5[0];
	assign cos_s5 = res_s5[1];

endmodule

/* design/tps_xform.sv */
// Torus point, normal, both rotations and the shade, four register stages.
`timescale 1ns / 1ps
module tps_xform #(
	parameter int SHADE_LEVELS = 8
) (
	input  logic                              clk,
	input  logic [3:0]                        stage_en,
	input  tps_pkg::trig_t                    ct,
	input  tps_pkg::trig_t                    st,
	input  tps_pkg::trig_t                    cp,
	input  tps_pkg::trig_t                    sp,
	input  tps_pkg::trig_t                    cx,
	input  tps_pkg::trig_t                    sx,
	input  tps_pkg::trig_t                    cz,
	input  tps_pkg::trig_t                    sz,
	output tps_pkg::coord_t                   rx_s9,
	output tps_pkg::coord_t                   ry_s9,
	output logic [20:0]                       zd_s9,
	output logic [$clog2(SHADE_LEVELS)-1:0]   shade_s9,
	output logic                              lit_s9
);
	import tps_pkg::*;

	localparam int SW = $clog2(SHADE_LEVELS);
	localparam logic signed [23:0] SL_S = 24'(SHADE_LEVELS);
	localparam logic signed [23:0] SMAX = 24'(SHADE_LEVELS - 1);

	logic signed [19:0] ring_s6;
	logic signed [17:0] pz_s6;
	logic signed [16:0] ny_s6;
	trig_t st_s6, cp_s6, sp_s6, cx_s6, sx_s6, cz_s6, sz_s6;

	logic signed [19:0] px_s7, py_s7;
	logic signed [17:0] pz_s7;
	logic signed [17:0] nz_s7;
	trig_t cx_s7, sx_s7, cz_s7, sz_s7;

	coord_t ry_s8, rz_s8;
	logic signed [19:0] px_s8;
	trig_t cz_s8, sz_s8;
	logic [SW-1:0] shade_s8;
	logic lit_s8;

	logic signed [23:0] light_c;
	logic signed [23:0] lvl_c;
	logic [SW-1:0] shade_c;

	// Ring radius, tube height and the normal's Y term.
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ring_s6 <= RING_R1 + 20'(ct) * TUBE_R2;
			pz_s6   <= 18'(st) * 18'(TUBE_R2);
			ny_s6   <= 17'(qtrunc(48'(ct) * 48'(sp)));
			st_s6   <= st;
			cp_s6   <= cp;
			sp_s6   <= sp;
			cx_s6   <= cx;
			sx_s6   <= sx;
			cz_s6   <= cz;
			sz_s6   <= sz;
		end
	end

	// Point on the torus and the normal's Z component after the X rotation.
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			px_s7 <= 20'(qtrunc(48'(ring_s6) * 48'(cp_s6)));
			py_s7 <= 20'(qtrunc(48'(ring_s6) * 48'(sp_s6)));
			pz_s7 <= pz_s6;
			nz_s7 <= 18'(qtrunc(48'(sx_s6) * 48'(ny_s6)))
				+ 18'(qtrunc(48'(cx_s6) * 48'(st_s6)));
			cx_s7 <= cx_s6;
			sx_s7 <= sx_s6;
			cz_s7 <= cz_s6;
			sz_s7 <= sz_s6;
		end
	end

	// Light value, clamped brightness index and the facing flag.
	always_comb begin
		light_c = -(24'(nz_s7) * SL_S);
		lvl_c   = light_c >>> 14;
		if (light_c <= 0) begin
			shade_c = '0;
		end else if (lvl_c > SMAX) begin
			shade_c = SW'(SMAX);
		end else begin
			shade_c = SW'(lvl_c);
		end
	end

	// Rotation about the X axis.
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			ry_s8 <= 21'(qtrunc(48'(cx_s7) * 48'(py_s7)))
				- 21'(qtrunc(48'(sx_s7) * 48'(pz_s7)));
			rz_s8 <= 21'(qtrunc(48'(sx_s7) * 48'(py_s7)))
				+ 21'(qtrunc(48'(cx_s7) * 48'(pz_s7)));
			px_s8    <= px_s7;
			cz_s8    <= cz_s7;
			sz_s8    <= sz_s7;
			shade_s8 <= shade_c;
			lit_s8   <= light_c > 0;
		end
	end

	// Rotation about the Z axis and the viewing distance.
	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			rx_s9 <= 21'(qtrunc(48'(cz_s8) * 48'(px_s8)))
				- 21'(qtrunc(48'(sz_s8) * 48'(ry_s8)));
			ry_s9 <= 21'(qtrunc(48'(sz_s8) * 48'(px_s8)))
				+ 21'(qtrunc(48'(cz_s8) * 48'(ry_s8)));
			zd_s9    <= 21'(22'(rz_s8) + VIEW_DIST);
			shade_s9 <= shade_s8;
			lit_s9   <= lit_s8;
		end
	end

endmodule

/* design/tps_proj.sv */
// Projection numerators and denominators, two register stages.
`timescale 1ns / 1ps
module tps_proj (
	input  logic                         clk,
	input  logic [1:0]                   stage_en,
	input  tps_pkg::coord_t              rx,
	input  tps_pkg::coord_t              ry,
	input  logic [20:0]                  zd,
	input  logic [9:0]                   scr_w,
	input  logic [9:0]                   scr_h,
	output logic [tps_pkg::MAG_W-1:0]    mag_x_s11,
	output logic [tps_pkg::MAG_W-1:0]    mag_y_s11,
	output logic                         neg_x_s11,
	output logic                         neg_y_s11,
	output logic [tps_pkg::DEN_W-1:0]    den_x_s11,
	output logic [tps_pkg::DEN_W-1:0]    den_y_s11,
	output logic [20:0]                  zd_s11
);
	import tps_pkg::*;

	logic signed [28:0] ax_s10, ay_s10;
	logic [DEN_W-1:0] dx_s10, dy_s10;
	logic [20:0] zd_s10;
	logic signed [MAG_W-1:0] nx_c, ny_c;
	logic signed [28:0] zds_c;

	assign zds_c = 29'($signed({1'b0, zd}));

	// Scaled offsets with the screen centre term folded in.
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ax_s10 <= 29'(rx) * PX_MUL + zds_c * PX_CTR;
			ay_s10 <= 29'(ry) * PX_MUL + zds_c * PY_CTR;
			dx_s10 <= DEN_W'(zd) * DX_MUL;
			dy_s10 <= DEN_W'(zd) * DY_MUL;
			zd_s10 <= zd;
		end
	end

	// Scale by the screen size and split into sign and magnitude.
	always_comb begin
		nx_c = MAG_W'(ax_s10) * MAG_W'($signed({1'b0, scr_w}));
		ny_c = MAG_W'(ay_s10) * MAG_W'($signed({1'b0, scr_h}));
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			neg_x_s11 <= nx_c < 0;
			neg_y_s11 <= ny_c < 0;
			mag_x_s11 <= (nx_c < 0) ? MAG_W'(-nx_c) : MAG_W'(nx_c);
			mag_y_s11 <= (ny_c < 0) ? MAG_W'(-ny_c) : MAG_W'(ny_c);
			den_x_s11 <= dx_s10;
			den_y_s11 <= dy_s10;
			zd_s11    <= zd_s10;
		end
	end

endmodule

/* design/tps_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module tps_div #(
	parameter int NW  = 40,
	parameter int DW  = 28,
	parameter int QW  = 12,
	parameter int SBW = 1
) (
	input  logic            clk,
	input  logic [QW-1:0]   stage_en,
	input  logic [NW-1:0]   num,
	input  logic [DW-1:0]   den,
	input  logic [SBW-1:0]  sb_in,
	output logic [QW-1:0]   quo,
	output logic [SBW-1:0]  sb_out
);
	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	// Entry 0 is the stage input; entry i+1 is the register of stage i.
	logic [RW-1:0]  rem_s [QW+1];
	logic [DW-1:0]  den_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic [SBW-1:0] sb_s  [QW+1];

	assign rem_s[0] = RW'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign sb_s[0]  = sb_in;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int B = QW - 1 - i;
		logic [RW-1:0] sh_c;
		logic [RW:0]   diff_c;

		// Trial subtraction of the divisor shifted to this bit.
		always_comb begin
			sh_c   = RW'(den_s[i]) << B;
			diff_c = {1'b0, rem_s[i]} - {1'b0, sh_c};
		end

		always_ff @(posedge clk) begin
			if (stage_en[i]) begin
				den_s[i+1] <= den_s[i];
				sb_s[i+1]  <= sb_s[i];
				if (!diff_c[RW]) begin
					rem_s[i+1]    <= diff_c[RW-1:0];
					quo_s[i+1]    <= quo_s[i] | (QW'(1) << B);
				end else begin
					rem_s[i+1]    <= rem_s[i];
					quo_s[i+1]    <= quo_s[i];
				end
			end
		end
	end

	assign quo    = quo_s[QW];
	assign sb_out = sb_s[QW];

endmodule

/* design/torus_point_shader.sv */
// Top level of the torus point shader: control, configuration and output stage.
// An input transfer passes through the trig, transform, projection and divider stages to the output register.
// Throughput: one sample per cycle while the output is not stalled; the twelve-stage dividers set the depth.
// Each stage holds its item while the next is full and held, so bubbles close up on a stall.
// Reset clears all valid bits and loads rotations 0, width 80 and height 40.
`timescale 1ns / 1ps
module torus_point_shader #(
	parameter int SHADE_LEVELS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [1:0]                       cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [8:0]                       tube_step,
	input  logic [8:0]                       ring_step,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [11:0]               pixel_x,
	output logic signed [11:0]               pixel_y,
	output logic [15:0]                      inv_depth,
	output logic [$clog2(SHADE_LEVELS)-1:0]  shade,
	output logic                             lit
);
	import tps_pkg::*;

	localparam int SW = $clog2(SHADE_LEVELS);

	logic [15:0] rot_x_q, rot_z_q;
	logic [9:0]  width_q, height_q;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] adv;

	angle_t tube_s1, ring_s1, rotx_s1, rotz_s1;
	trig_t st_s5, ct_s5, sp_s5, cp_s5, sx_s5, cx_s5, sz_s5, cz_s5;
	coord_t rx_s9, ry_s9;
	logic [20:0] zd_s9, zd_s11;
	logic [SW-1:0] shade_s9;
	logic lit_s9;
	logic [MAG_W-1:0] mag_x_s11, mag_y_s11;
	logic neg_x_s11, neg_y_s11;
	logic [DEN_W-1:0] den_x_s11, den_y_s11;

	logic [SW-1:0] shade_s10, shade_s11;
	logic lit_s10, lit_s11;

	logic [DIV_QW-1:0] qx_s23, qy_s23, qz_s23;
	logic [SW:0] sbx_s23;
	logic sby_s23, sbz_s23;

	logic [11:0] pix_x_s24, pix_y_s24;
	logic [15:0] ooz_s24;
	logic [SW-1:0] shade_s24;
	logic lit_s24;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q  <= '0;
			rot_z_q  <= '0;
			width_q  <= 10'd80;
			height_q <= 10'd40;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ROT_X:  rot_x_q  <= cfg_data;
				CFG_ROT_Z:  rot_z_q  <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[9:0];
				CFG_HEIGHT: height_q <= cfg_data[9:0];
			endcase
		end
	end

	// A stage moves on when it is empty or its successor moves on.
	always_comb begin
		adv[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NSTG];

	// Step indexes to binary angles, rounded.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			tube_s1 <= angle_t'((34'(tube_step) * STEP_MUL + STEP_RND) >> 16);
			ring_s1 <= angle_t'((34'(ring_step) * STEP_MUL + STEP_RND) >> 16);
			rotx_s1 <= rot_x_q;
			rotz_s1 <= rot_z_q;
		end
	end

	tps_trig u_trig_tube (
		.clk(clk), .stage_en(adv[5:2]), .ang(tube_s1), .sin_s5(st_s5), .cos_s5(ct_s5)
	);
	tps_trig u_trig_ring (
		.clk(clk), .stage_en(adv[5:2]), .ang(ring_s1), .sin_s5(sp_s5), .cos_s5(cp_s5)
	);
	tps_trig u_trig_rotx (
		.clk(clk), .stage_en(adv[5:2]), .ang(rotx_s1), .sin_s5(sx_s5), .cos_s5(cx_s5)
	);
	tps_trig u_trig_rotz (
		.clk(clk), .stage_en(adv[5:2]), .ang(rotz_s1), .sin_s5(sz_s5), .cos_s5(cz_s5)
	);

	tps_xform #(
		.SHADE_LEVELS(SHADE_LEVELS)
	) u_xform (
		.clk(clk), .stage_en(adv[9:6]),
		.ct(ct_s5), .st(st_s5), .cp(cp_s5), .sp(sp_s5),
		.cx(cx_s5), .sx(sx_s5), .cz(cz_s5), .sz(sz_s5),
		.rx_s9(rx_s9), .ry_s9(ry_s9), .zd_s9(zd_s9),
		.shade_s9(shade_s9), .lit_s9(lit_s9)
	);

	tps_proj u_proj (
		.clk(clk), .stage_en(adv[11:10]),
		.rx(rx_s9), .ry(ry_s9), .zd(zd_s9), .scr_w(width_q), .scr_h(height_q),
		.mag_x_s11(mag_x_s11), .mag_y_s11(mag_y_s11),
		.neg_x_s11(neg_x_s11), .neg_y_s11(neg_y_s11),
		.den_x_s11(den_x_s11), .den_y_s11(den_y_s11), .zd_s11(zd_s11)
	);

	// Shade and facing flag ride alongside the projection stages.
	always_ff @(posedge clk) begin
		if (adv[10]) begin
			shade_s10 <= shade_s9;
			lit_s10   <= lit_s9;
		end
		if (adv[11]) begin
			shade_s11 <= shade_s10;
			lit_s11   <= lit_s10;
		end
	end

	tps_div #(
		.NW(MAG_W), .DW(DEN_W), .QW(DIV_QW), .SBW(SW + 1)
	) u_div_x (
		.clk(clk), .stage_en(adv[23:12]), .num(mag_x_s11), .den(den_x_s11),
		.sb_in({neg_x_s11, shade_s11}), .quo(qx_s23), .sb_out(sbx_s23)
	);

	tps_div #(
		.NW(MAG_W), .DW(DEN_W), .QW(DIV_QW), .SBW(1)
	) u_div_y (
		.clk(clk), .stage_en(adv[23:12]), .num(mag_y_s11), .den(den_y_s11),
		.sb_in(neg_y_s11), .quo(qy_s23), .sb_out(sby_s23)
	);

	tps_div #(
		.NW(MAG_W), .DW(DEN_W), .QW(DIV_QW), .SBW(1)
	) u_div_z (
		.clk(clk), .stage_en(adv[23:12]), .num(OOZ_NUM), .den(DEN_W'(zd_s11)),
		.sb_in(lit_s11), .quo(qz_s23), .sb_out(sbz_s23)
	);

	// Output register: restore the signs of the quotients.
	always_ff @(posedge clk) begin
		if (adv[NSTG]) begin
			pix_x_s24 <= sbx_s23[SW] ? 12'(12'd0 - qx_s23) : 12'(qx_s23);
			pix_y_s24 <= sby_s23 ? 12'(12'd0 - qy_s23) : 12'(qy_s23);
			ooz_s24   <= 16'(qz_s23);
			shade_s24 <= sbx_s23[SW-1:0];
			lit_s24   <= sbz_s23;
		end
	end

	assign pixel_x   = $signed(pix_x_s24);
	assign pixel_y   = $signed(pix_y_s24);
	assign inv_depth = ooz_s24;
	assign shade     = shade_s24;
	assign lit       = lit_s24;

	// The input is held off only while the first stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_q[1])
		else $error("input held off with an empty first stage");

	// An accepted transfer always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[1])
		else $error("accepted transfer lost at the first stage");

	// A sample facing away carries no brightness.
	a_unlit_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !lit) |-> (shade == '0))
		else $error("unlit sample with non-zero shade");

	// Brightness index stays within the ramp.
	a_shade_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shade <= SW'(SHADE_LEVELS - 1)))
		else $error("shade above the top level");

	// The viewing distance keeps the inverse depth well inside eleven bits.
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inv_depth != 16'd0 && inv_depth < 16'd2048))
		else $error("inverse depth out of range");

endmodule
